### hdl/kspc_pkg.sv
// Shared constants and types of the key scan press classifier.
`default_nettype none
package kspc_pkg;

	localparam int CNT_W     = 15;
	localparam int CFG_IDX_W = 1;

	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [1:0] key_t;
	typedef logic [2:0] msg_t;
	typedef logic [1:0] phase_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	// Configuration register indexes.
	localparam cfg_idx_t CFG_LONG_PRESS_TICKS = 1'd0;
	localparam cfg_idx_t CFG_REPEAT_TICKS     = 1'd1;

	localparam cnt_t LONG_PRESS_TICKS_RST = 15'd150;
	localparam cnt_t REPEAT_TICKS_RST     = 15'd50;

	// Scan phases.
	localparam phase_t PH_DETECT  = 2'd0;
	localparam phase_t PH_PRESS   = 2'd1;
	localparam phase_t PH_RELEASE = 2'd2;

	// Key codes.
	localparam key_t KEY_NONE = 2'd0;
	localparam key_t KEY_ONE  = 2'd1;
	localparam key_t KEY_TWO  = 2'd2;

	// Message codes.
	localparam msg_t MSG_NONE         = 3'd0;
	localparam msg_t MSG_PRESS_EDGE   = 3'd1;
	localparam msg_t MSG_PRESS        = 3'd2;
	localparam msg_t MSG_RELEASE_EDGE = 3'd3;
	localparam msg_t MSG_LONG_EDGE    = 3'd4;
	localparam msg_t MSG_LONG         = 3'd5;
	localparam msg_t MSG_MULTI        = 3'd6;

endpackage
`default_nettype wire

### hdl/kspc_ifs.sv
// Handshake interfaces for the scan tick, result and configuration channels.
`default_nettype none
interface kspc_tick_if;
	logic valid;
	logic ready;
	logic key_one_down;
	logic key_two_down;
	logic take;

	modport source (output valid, key_one_down, key_two_down, take, input ready);
	modport sink (input valid, key_one_down, key_two_down, take, output ready);
endinterface

interface kspc_result_if import kspc_pkg::*; ;
	logic valid;
	logic ready;
	logic read_valid;
	key_t read_key;
	msg_t read_message;

	modport source (output valid, read_valid, read_key, read_message, input ready);
	modport sink (input valid, read_valid, read_key, read_message, output ready);
endinterface

interface kspc_cfg_if import kspc_pkg::*; ;
	logic valid;
	logic ready;
	cfg_idx_t index;
	cnt_t data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

### hdl/key_scan_press_classifier_core.sv
// Two-key scan tick, debounce, press classification and message slot.
//
// Every tick word carries two raw key levels (key one wins) and a take flag, and
// yields exactly one result word. The block accepts one tick per clock cycle; the
// result of a tick shows on the result channel in the cycle after it is accepted.
// All scan state updates in the cycle of acceptance, and a single output register
// holds the result, so ticks keep flowing as long as the result side takes words.
// Configuration writes are taken in every cycle and should come only while idle.
`default_nettype none
module key_scan_press_classifier_core import kspc_pkg::*; (
	input  wire          clk,
	input  wire          arst_n,
	kspc_tick_if.sink    tick,
	kspc_result_if.source result,
	kspc_cfg_if.sink     cfg
);

	cnt_t   long_press_ticks_q;
	cnt_t   repeat_ticks_q;

	phase_t scan_phase_q;
	key_t   filtered_key_q;
	cnt_t   repeat_count_q;
	logic   repeat_pending_q;
	cnt_t   long_count_q;
	logic   long_active_q;
	key_t   slot_key_q;
	msg_t   slot_message_q;

	logic   res_valid_q;
	logic   res_read_valid_q;
	key_t   res_read_key_q;
	msg_t   res_read_message_q;

	logic   accept;
	key_t   now;
	logic   slot_full;
	logic   rd_valid;
	logic   slot_free;

	phase_t scan_phase_d;
	key_t   filtered_key_d;
	cnt_t   repeat_count_d;
	logic   repeat_pending_d;
	cnt_t   long_count_d;
	logic   long_active_d;
	key_t   slot_key_d;
	msg_t   slot_message_d;

	logic   post_req;
	key_t   post_key;
	msg_t   post_msg;
	logic   timed;
	cnt_t   rep_inc;
	cnt_t   long_inc;

	assign cfg.ready  = 1'b1;
	assign tick.ready = !res_valid_q || result.ready;
	assign accept     = tick.valid && tick.ready;

	assign result.valid        = res_valid_q;
	assign result.read_valid   = res_read_valid_q;
	assign result.read_key     = res_read_key_q;
	assign result.read_message = res_read_message_q;

	assign now       = tick.key_one_down ? KEY_ONE : (tick.key_two_down ? KEY_TWO : KEY_NONE);
	assign slot_full = (slot_key_q != KEY_NONE) || (slot_message_q != MSG_NONE);
	assign rd_valid  = tick.take && slot_full;
	// A post this tick lands only if the slot is empty after any read.
	assign slot_free = !slot_full || tick.take;
	assign rep_inc   = repeat_count_q + cnt_t'(1);
	assign long_inc  = long_count_q + cnt_t'(1);

	always_comb begin
		scan_phase_d     = scan_phase_q;
		filtered_key_d   = filtered_key_q;
		repeat_count_d   = repeat_count_q;
		repeat_pending_d = repeat_pending_q;
		long_count_d     = long_count_q;
		long_active_d    = long_active_q;
		post_req         = 1'b0;
		post_key         = now;
		post_msg         = MSG_NONE;
		timed            = 1'b0;

		case (scan_phase_q)
			PH_DETECT: begin
				if (now == filtered_key_q) begin
					if (now != KEY_NONE) begin
						repeat_count_d   = '0;
						repeat_pending_d = 1'b0;
						long_count_d     = '0;
						long_active_d    = 1'b0;
						scan_phase_d     = PH_PRESS;
						post_req         = 1'b1;
						post_msg         = MSG_PRESS_EDGE;
					end else begin
						scan_phase_d = PH_RELEASE;
					end
				end else begin
					filtered_key_d = now;
				end
			end
			PH_PRESS: begin
				if (now == filtered_key_q) begin
					// Held key: a pending repeat goes first, then the repeat
					// timer, then the long-press timer, else a plain press.
					timed = 1'b1;
					if (repeat_pending_q) begin
						post_req = 1'b1;
						post_msg = MSG_MULTI;
						if (slot_free) begin
							repeat_pending_d = 1'b0;
						end
					end else if (rep_inc >= repeat_ticks_q) begin
						repeat_count_d = '0;
						post_req       = 1'b1;
						post_msg       = MSG_MULTI;
						if (!slot_free) begin
							repeat_pending_d = 1'b1;
						end
					end else begin
						repeat_count_d = rep_inc;
						if (long_active_q) begin
							post_req = 1'b1;
							post_msg = MSG_LONG;
						end else begin
							long_count_d = long_inc;
							if (long_inc >= long_press_ticks_q) begin
								long_active_d = 1'b1;
								post_req      = 1'b1;
								post_msg      = MSG_LONG_EDGE;
							end else begin
								timed = 1'b0;
							end
						end
					end
					if (!timed) begin
						post_req = 1'b1;
						post_msg = MSG_PRESS;
					end
				end else begin
					repeat_count_d   = '0;
					repeat_pending_d = 1'b0;
					long_count_d     = '0;
					long_active_d    = 1'b0;
					post_req         = 1'b1;
					post_key         = filtered_key_q;
					post_msg         = MSG_RELEASE_EDGE;
					filtered_key_d   = now;
					scan_phase_d     = PH_DETECT;
				end
			end
			PH_RELEASE: begin
				if (now != KEY_NONE) begin
					filtered_key_d = now;
					scan_phase_d   = PH_DETECT;
				end
			end
			default: begin
			end
		endcase

		if (post_req && slot_free) begin
			slot_key_d     = post_key;
			slot_message_d = post_msg;
		end else if (tick.take) begin
			slot_key_d     = KEY_NONE;
			slot_message_d = MSG_NONE;
		end else begin
			slot_key_d     = slot_key_q;
			slot_message_d = slot_message_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_press_ticks_q <= LONG_PRESS_TICKS_RST;
			repeat_ticks_q     <= REPEAT_TICKS_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_LONG_PRESS_TICKS: long_press_ticks_q <= cfg.data;
				CFG_REPEAT_TICKS:     repeat_ticks_q     <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_phase_q     <= PH_DETECT;
			filtered_key_q   <= KEY_NONE;
			repeat_count_q   <= '0;
			repeat_pending_q <= 1'b0;
			long_count_q     <= '0;
			long_active_q    <= 1'b0;
			slot_key_q       <= KEY_NONE;
			slot_message_q   <= MSG_NONE;
		end else if (accept) begin
			scan_phase_q     <= scan_phase_d;
			filtered_key_q   <= filtered_key_d;
			repeat_count_q   <= repeat_count_d;
			repeat_pending_q <= repeat_pending_d;
			long_count_q     <= long_count_d;
			long_active_q    <= long_active_d;
			slot_key_q       <= slot_key_d;
			slot_message_q   <= slot_message_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_read_valid_q   <= rd_valid;
			res_read_key_q     <= rd_valid ? slot_key_q : KEY_NONE;
			res_read_message_q <= rd_valid ? slot_message_q : MSG_NONE;
		end
	end

endmodule
`default_nettype wire
